FILE: design/pscomp_pkg.sv
`default_nettype none

package pscomp_pkg;

	localparam int unsigned COEF_W = 16;
	localparam int unsigned RAW_W = 24;
	localparam int unsigned TEMP_W = 19;
	localparam int unsigned PRES_W = 27;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned NUM_STAGES = 8;

	localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_SENSITIVITY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_OFFSET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY_TEMP_COEF = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP_COEF = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_TEMPERATURE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TEMPERATURE_COEF = 3'd5;

	localparam logic signed [TEMP_W-1:0] TEMP_REF = 19'sd2000;

	localparam int unsigned SH_TEMP = 23;
	localparam int unsigned SH_OFF = 6;
	localparam int unsigned SH_SENS = 7;
	localparam int unsigned SH_TCORR = 35;
	localparam int unsigned SH_OFFC = 3;
	localparam int unsigned SH_SENSC = 5;
	localparam int unsigned SH_PROD = 21;
	localparam int unsigned SH_PRES = 15;

	// Signed division by a power of two that rounds toward zero.
	function automatic logic signed [63:0] sdiv_pow2(input logic signed [63:0] x,
			input int unsigned sh);
		logic signed [63:0] bias;
		bias = x[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
		return (x + bias) >>> sh;
	endfunction

endpackage

`default_nettype wire

FILE: design/pressure_sensor_compensation_top.sv
// Second-order barometric compensation pipeline. Each beat on the input channel
// carries a raw pressure and a raw temperature count; each beat on the output
// channel carries the compensated temperature (0.01 degC) and pressure (0.01 mbar).
// One sample enters per clock while in_ready is high, and its result passes through
// the eight register stages of the multiply chain. Every stage holds its own valid
// bit, so empty stages fill while the output is stalled and the input stops only
// when all eight stages hold data. Calibration words are written through
// cfg_write/cfg_index/cfg_data and must be stable while samples are in flight;
// indexes six and seven are ignored.
`default_nettype none

module pressure_sensor_compensation_top (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_write,
	input  wire logic [pscomp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [pscomp_pkg::COEF_W-1:0]          cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic [pscomp_pkg::RAW_W-1:0]           raw_pressure,
	input  wire logic [pscomp_pkg::RAW_W-1:0]           raw_temperature,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [pscomp_pkg::TEMP_W-1:0]        temperature_centideg,
	output logic signed [pscomp_pkg::PRES_W-1:0]        pressure_centimbar
);

	logic [pscomp_pkg::COEF_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

	logic [pscomp_pkg::NUM_STAGES-1:0] stage_valid_q;
	logic [pscomp_pkg::NUM_STAGES-1:0] stage_en;

	logic [pscomp_pkg::RAW_W-1:0] d1_s1, d1_s2, d1_s3, d1_s4, d1_s5;
	logic signed [24:0] dt_s1;

	logic signed [41:0] tprod_s2, oprod_s2, sprod_s2;
	logic [47:0] dsq_s2;

	logic signed [18:0] q_s3, temp1_s3, temp1_s4;
	logic signed [36:0] off1_s3, sens1_s3, off1_s4, sens1_s4;
	logic [16:0] tcorr_s3, tcorr_s4;

	logic [34:0] sq_s4;
	logic low_s4, low_s5;

	logic signed [39:0] off_s5, sens_s5, off_s6, off_s7;
	logic signed [18:0] temp_s5, temp_s6, temp_s7, temp_s8;

	logic [43:0] plo_s6;
	logic signed [44:0] phi_s6;

	logic signed [42:0] x_s7;
	logic signed [26:0] pres_s8;

	logic signed [24:0] dt_d;
	logic signed [41:0] tprod_d, oprod_d, sprod_d;
	logic signed [49:0] dsq_full;
	logic signed [63:0] tdiv, odiv, sdiv;
	logic [51:0] dsq11;
	logic signed [37:0] qsq;
	logic [39:0] offc31;
	logic [40:0] sensc63;
	logic signed [39:0] offc, sensc;
	logic [43:0] plo_d;
	logic signed [44:0] phi_d;
	logic signed [63:0] prod, pdiv;
	logic signed [43:0] pdiff;
	logic signed [63:0] pres_div;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= '0;
			c2_q <= '0;
			c3_q <= '0;
			c4_q <= '0;
			c5_q <= '0;
			c6_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				pscomp_pkg::REG_PRESSURE_SENSITIVITY: c1_q <= cfg_data;
				pscomp_pkg::REG_PRESSURE_OFFSET: c2_q <= cfg_data;
				pscomp_pkg::REG_SENSITIVITY_TEMP_COEF: c3_q <= cfg_data;
				pscomp_pkg::REG_OFFSET_TEMP_COEF: c4_q <= cfg_data;
				pscomp_pkg::REG_REFERENCE_TEMPERATURE: c5_q <= cfg_data;
				pscomp_pkg::REG_TEMPERATURE_COEF: c6_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or when the stage after it loads too.
	always_comb begin
		stage_en[pscomp_pkg::NUM_STAGES-1] = !stage_valid_q[pscomp_pkg::NUM_STAGES-1]
			|| out_ready;
		for (int k = pscomp_pkg::NUM_STAGES - 2; k >= 0; k--) begin
			stage_en[k] = !stage_valid_q[k] || stage_en[k+1];
		end
	end

	assign in_ready = stage_en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (stage_en[0]) begin
				stage_valid_q[0] <= in_valid;
			end
			for (int k = 1; k < pscomp_pkg::NUM_STAGES; k++) begin
				if (stage_en[k]) begin
					stage_valid_q[k] <= stage_valid_q[k-1];
				end
			end
		end
	end

	always_comb begin
		dt_d = $signed({1'b0, raw_temperature}) - $signed({1'b0, c5_q, 8'b0});

		tprod_d = dt_s1 * $signed({1'b0, c6_q});
		oprod_d = dt_s1 * $signed({1'b0, c4_q});
		sprod_d = dt_s1 * $signed({1'b0, c3_q});
		dsq_full = dt_s1 * dt_s1;

		tdiv = pscomp_pkg::sdiv_pow2(64'(tprod_s2), pscomp_pkg::SH_TEMP);
		odiv = pscomp_pkg::sdiv_pow2(64'(oprod_s2), pscomp_pkg::SH_OFF);
		sdiv = pscomp_pkg::sdiv_pow2(64'(sprod_s2), pscomp_pkg::SH_SENS);
		dsq11 = {1'b0, dsq_s2, 3'b0} + {3'b0, dsq_s2, 1'b0} + {4'b0, dsq_s2};

		qsq = q_s3 * q_s3;

		offc31 = {sq_s4, 5'b0} - {5'b0, sq_s4};
		sensc63 = {sq_s4, 6'b0} - {6'b0, sq_s4};
		offc = $signed({3'b0, offc31[39:pscomp_pkg::SH_OFFC]});
		sensc = $signed({4'b0, sensc63[40:pscomp_pkg::SH_SENSC]});

		plo_d = d1_s5 * sens_s5[19:0];
		phi_d = $signed({1'b0, d1_s5}) * $signed(sens_s5[39:20]);

		prod = (64'(phi_s6) <<< 20) + $signed({20'b0, plo_s6});
		pdiv = pscomp_pkg::sdiv_pow2(prod, pscomp_pkg::SH_PROD);

		pdiff = 44'(x_s7) - 44'(off_s7);
		pres_div = pscomp_pkg::sdiv_pow2(64'(pdiff), pscomp_pkg::SH_PRES);
	end

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			d1_s1 <= raw_pressure;
			dt_s1 <= dt_d;
		end
		if (stage_en[1]) begin
			d1_s2 <= d1_s1;
			tprod_s2 <= tprod_d;
			oprod_s2 <= oprod_d;
			sprod_s2 <= sprod_d;
			dsq_s2 <= dsq_full[47:0];
		end
		if (stage_en[2]) begin
			d1_s3 <= d1_s2;
			q_s3 <= tdiv[18:0];
			temp1_s3 <= pscomp_pkg::TEMP_REF + tdiv[18:0];
			off1_s3 <= $signed({4'b0, c2_q, 17'b0}) + odiv[36:0];
			sens1_s3 <= $signed({5'b0, c1_q, 16'b0}) + sdiv[36:0];
			tcorr_s3 <= dsq11[51:pscomp_pkg::SH_TCORR];
		end
		if (stage_en[3]) begin
			d1_s4 <= d1_s3;
			sq_s4 <= qsq[34:0];
			low_s4 <= q_s3[18];
			temp1_s4 <= temp1_s3;
			off1_s4 <= off1_s3;
			sens1_s4 <= sens1_s3;
			tcorr_s4 <= tcorr_s3;
		end
		if (stage_en[4]) begin
			d1_s5 <= d1_s4;
			low_s5 <= low_s4;
			off_s5 <= low_s4 ? 40'(off1_s4) - offc : 40'(off1_s4);
			sens_s5 <= low_s4 ? 40'(sens1_s4) - sensc : 40'(sens1_s4);
			temp_s5 <= low_s4 ? temp1_s4 - $signed({2'b0, tcorr_s4}) : temp1_s4;
		end
		if (stage_en[5]) begin
			plo_s6 <= plo_d;
			phi_s6 <= phi_d;
			off_s6 <= off_s5;
			temp_s6 <= temp_s5;
		end
		if (stage_en[6]) begin
			x_s7 <= pdiv[42:0];
			off_s7 <= off_s6;
			temp_s7 <= temp_s6;
		end
		if (stage_en[7]) begin
			pres_s8 <= pres_div[26:0];
			temp_s8 <= temp_s7;
		end
	end

	assign out_valid = stage_valid_q[pscomp_pkg::NUM_STAGES-1];
	assign temperature_centideg = temp_s8;
	assign pressure_centimbar = pres_s8;

`ifndef SYNTH
	a_empty_first_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!stage_valid_q[0] |-> in_ready)
		else $error("input blocked while the first stage is empty");

	a_full_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(&stage_valid_q) && !out_ready |-> !in_ready)
		else $error("input taken while every stage is full and the output stalls");

	a_held_stage_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		stage_valid_q[4] && !stage_en[4] |=> stage_valid_q[4] && $stable(temp_s5))
		else $error("stalled stage lost its sample");

	a_low_branch_cold: assert property (@(posedge clk) disable iff (!arst_n)
		stage_valid_q[4] && low_s5 |-> temp_s5 < pscomp_pkg::TEMP_REF)
		else $error("second-order path gave a temperature at or above 20 degC");

	a_high_branch_warm: assert property (@(posedge clk) disable iff (!arst_n)
		stage_valid_q[4] && !low_s5 |-> temp_s5 >= pscomp_pkg::TEMP_REF)
		else $error("first-order path gave a temperature below 20 degC");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_pressure_sensor_compensation_top.sv
module tb_pressure_sensor_compensation_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pscomp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;
	localparam int unsigned NUM_COEFS = 6;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam logic [RAW_W-1:0] RAW_MAX = 24'hFFFFFF;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature;
		logic signed [PRES_W-1:0] pressure;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [RAW_W-1:0] raw_pressure;
	logic [RAW_W-1:0] raw_temperature;
	logic out_valid;
	logic out_ready;
	logic signed [TEMP_W-1:0] temperature_centideg;
	logic signed [PRES_W-1:0] pressure_centimbar;

	logic [COEF_W-1:0] coef_shadow [NUM_COEFS];
	reading_t expected_readings[$];
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;
	bit tx_idling = 1'b1;
	bit rx_idling = 1'b1;
	bit hold_request = 1'b0;

	pressure_sensor_compensation_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.raw_pressure(raw_pressure),
		.raw_temperature(raw_temperature),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.temperature_centideg(temperature_centideg),
		.pressure_centimbar(pressure_centimbar)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic reading_t compensate(input logic [RAW_W-1:0] d1_raw,
			input logic [RAW_W-1:0] d2_raw);
		longint d1, d2, c1, c2, c3, c4, c5, c6;
		longint dt, temp, off, sens, pres, below, sq;
		reading_t r;
		d1 = longint'(d1_raw);
		d2 = longint'(d2_raw);
		c1 = longint'(coef_shadow[REG_PRESSURE_SENSITIVITY]);
		c2 = longint'(coef_shadow[REG_PRESSURE_OFFSET]);
		c3 = longint'(coef_shadow[REG_SENSITIVITY_TEMP_COEF]);
		c4 = longint'(coef_shadow[REG_OFFSET_TEMP_COEF]);
		c5 = longint'(coef_shadow[REG_REFERENCE_TEMPERATURE]);
		c6 = longint'(coef_shadow[REG_TEMPERATURE_COEF]);
		dt = d2 - c5 * 256;
		temp = 2000 + (dt * c6) / (64'sd1 <<< SH_TEMP);
		off = c2 * (64'sd1 <<< 17) + (c4 * dt) / (64'sd1 <<< SH_OFF);
		sens = c1 * (64'sd1 <<< 16) + (c3 * dt) / (64'sd1 <<< SH_SENS);
		if (temp < 2000) begin
			below = temp - 2000;
			sq = below * below;
			off = off - (31 * sq) / (64'sd1 <<< SH_OFFC);
			sens = sens - (63 * sq) / (64'sd1 <<< SH_SENSC);
			temp = temp - (11 * dt * dt) / (64'sd1 <<< SH_TCORR);
		end
		pres = ((d1 * sens) / (64'sd1 <<< SH_PROD) - off) / (64'sd1 <<< SH_PRES);
		r.temperature = temp[TEMP_W-1:0];
		r.pressure = pres[PRES_W-1:0];
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [COEF_W-1:0] pick_coef();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return COEF_W'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	// Most temperatures land near the reference point so both branches are hit often.
	function automatic logic [RAW_W-1:0] pick_raw_temperature();
		longint v;
		if ($urandom_range(0, 3) == 0)
			return RAW_W'($urandom_range(0, RAW_MAX));
		v = longint'(coef_shadow[REG_REFERENCE_TEMPERATURE]) * 256
			+ longint'($urandom_range(0, 2097152)) - 1048576;
		if (v < 0)
			v = 0;
		if (v > longint'(RAW_MAX))
			v = longint'(RAW_MAX);
		return v[RAW_W-1:0];
	endfunction

	task automatic send_sample(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t);
		int unsigned gap;
		gap = tx_idling ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_pressure <= p;
		raw_temperature <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_readings.push_back(compensate(p, t));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_PRESSURE_SENSITIVITY, REG_PRESSURE_OFFSET, REG_SENSITIVITY_TEMP_COEF,
			REG_OFFSET_TEMP_COEF, REG_REFERENCE_TEMPERATURE, REG_TEMPERATURE_COEF:
				coef_shadow[idx] = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_calibration(input logic [COEF_W-1:0] c1, input logic [COEF_W-1:0] c2,
			input logic [COEF_W-1:0] c3, input logic [COEF_W-1:0] c4,
			input logic [COEF_W-1:0] c5, input logic [COEF_W-1:0] c6);
		wait_idle();
		write_reg(REG_PRESSURE_SENSITIVITY, c1);
		write_reg(REG_PRESSURE_OFFSET, c2);
		write_reg(REG_SENSITIVITY_TEMP_COEF, c3);
		write_reg(REG_OFFSET_TEMP_COEF, c4);
		write_reg(REG_REFERENCE_TEMPERATURE, c5);
		write_reg(REG_TEMPERATURE_COEF, c6);
		cfg_write <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		send_sample('0, '0);
		send_sample(RAW_MAX, RAW_MAX);
		send_sample(24'hAAAAAA, 24'h555555);
	endtask

	task automatic test_raw_extremes();
		load_calibration(16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146);
		send_sample('0, '0);
		send_sample(RAW_MAX, RAW_MAX);
		send_sample(RAW_MAX, '0);
		send_sample('0, RAW_MAX);
		send_sample(24'h555555, 24'hAAAAAA);
		send_sample(24'hAAAAAA, 24'h555555);
		send_sample(24'd4958179, 24'd6815414);
		send_sample(24'd4958179, 24'd6821376);
	endtask

	task automatic test_coefficient_extremes();
		load_calibration('1, '1, '1, '1, '1, '1);
		send_sample(RAW_MAX, '0);
		send_sample(RAW_MAX, RAW_MAX);
		send_sample('0, 24'h800000);
		send_sample(RAW_MAX, 24'hFFFEFF);
		load_calibration('0, '0, '0, '0, '0, '0);
		send_sample(RAW_MAX, RAW_MAX);
		send_sample(RAW_MAX, '0);
		send_sample('0, RAW_MAX);
	endtask

	task automatic test_unused_indexes();
		load_calibration(16'h8000, 16'h4000, 16'h1234, 16'hFEDC, 16'h6000, 16'h7FFF);
		@(posedge clk);
		write_reg(REG_UNUSED_6, '1);
		write_reg(REG_UNUSED_7, '1);
		write_reg(REG_UNUSED_7, '0);
		cfg_write <= 1'b0;
		send_sample(24'h123456, 24'h5FFFFF);
		send_sample(24'hFEDCBA, 24'h600100);
	endtask

	task automatic test_output_stall();
		tx_idling = 1'b0;
		hold_request = 1'b1;
		repeat (40)
			send_sample(RAW_W'($urandom_range(0, RAW_MAX)), pick_raw_temperature());
		wait_idle();
		tx_idling = 1'b1;
		repeat (30)
			send_sample(RAW_W'($urandom_range(0, RAW_MAX)), pick_raw_temperature());
		wait_idle();
		repeat (30)
			send_sample(RAW_W'($urandom_range(0, RAW_MAX)), pick_raw_temperature());
	endtask

	task automatic test_random_calibrations();
		for (int phase = 0; phase < 8; phase++) begin
			if (phase == 0)
				load_calibration('1, '1, '1, '1, '1, '1);
			else if (phase == 1)
				load_calibration('0, '0, '0, '0, '0, '0);
			else
				load_calibration(pick_coef(), pick_coef(), pick_coef(), pick_coef(),
					pick_coef(), pick_coef());
			tx_idling = (phase % 3) != 2;
			rx_idling = (phase % 4) != 3;
			repeat (240)
				send_sample(RAW_W'($urandom_range(0, RAW_MAX)), pick_raw_temperature());
		end
		tx_idling = 1'b1;
		rx_idling = 1'b1;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		raw_pressure <= '0;
		raw_temperature <= '0;
		for (int i = 0; i < NUM_COEFS; i++)
			coef_shadow[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_raw_extremes();
		test_coefficient_extremes();
		test_unused_indexes();
		test_output_stall();
		test_random_calibrations();
		wait_idle();
		repeat (2 * NUM_STAGES) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		int unsigned n;
		out_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				n = HOLD_CYCLES;
			end else begin
				n = rx_idling ? pick_gap() : 0;
			end
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		reading_t exp_reading;
		if (arst_n && out_valid && out_ready) begin
			if (expected_readings.size() == 0) begin
				$error("result beat with no sample outstanding: temperature %0d pressure %0d",
					temperature_centideg, pressure_centimbar);
				mismatch_count++;
			end else begin
				exp_reading = expected_readings.pop_front();
				if (temperature_centideg !== exp_reading.temperature) begin
					$error("temperature_centideg expected %0d actual %0d",
						exp_reading.temperature, temperature_centideg);
					mismatch_count++;
				end
				if (pressure_centimbar !== exp_reading.pressure) begin
					$error("pressure_centimbar expected %0d actual %0d",
						exp_reading.pressure, pressure_centimbar);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
